// ===== design/pmbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pmbf_pkg
// Types and constants shared by the pluggable module bring-up controller.
// ----------------------------------------------------------------------------
package pmbf_pkg;

  localparam logic [7:0] TolLimitReset = 8'd10;

  localparam logic [7:0] ValA0Start = 8'h20;
  localparam logic [7:0] ValPollEn  = 8'h10;
  localparam logic [7:0] ValPageBit = 8'h40;
  localparam logic [7:0] ValModeBit = 8'h80;

  typedef enum logic [2:0] {
    ST_DETECT     = 3'd0,
    ST_INIT_RESET = 3'd1,
    ST_INIT_DONE  = 3'd2,
    ST_A0_BUSY    = 3'd3,
    ST_A0_DONE    = 3'd4,
    ST_A2_BUSY    = 3'd5,
    ST_A2_DONE    = 3'd6
  } state_e;

  typedef struct packed {
    logic module_present;
    logic a0_ready_to_start;
    logic a0_complete;
    logic a2_complete;
    logic a0_error;
    logic a2_error;
    logic start_acknowledged;
    logic multi_page_flag;
    logic addr_mode_flag;
  } in_t;

  typedef struct packed {
    logic       conf_write_valid;
    logic [7:0] conf_write_value;
    logic       init_pulse;
    logic [2:0] state_code;
    logic       connected;
  } out_t;

  typedef struct packed {
    state_e     state;
    logic [7:0] tol_left;
  } ctx_t;

endpackage

// ===== design/pmbf_if.sv =====
// ----------------------------------------------------------------------------
// pmbf_if
// Valid/ready request channels for poll ticks and results.
// ----------------------------------------------------------------------------
interface pmbf_in_if
  import pmbf_pkg::*;
  ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pmbf_out_if
  import pmbf_pkg::*;
  ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pmbf_step.sv =====
// ----------------------------------------------------------------------------
// pmbf_step
// Next state, tolerance count and result for one poll tick.
// ----------------------------------------------------------------------------
module pmbf_step
  import pmbf_pkg::*;
(
  input  ctx_t       ctx_i,
  input  logic [7:0] tol_limit_i,
  input  in_t        tick_i,
  output ctx_t       ctx_o,
  output out_t       res_o
);

  state_e     st;
  logic       run_out;
  logic       wr;
  logic [7:0] wval;
  logic       init;

  assign run_out = (ctx_i.tol_left == 8'd1);

  always_comb begin
    st       = ctx_i.state;
    ctx_o    = ctx_i;
    wr       = 1'b0;
    wval     = 8'h00;
    init     = 1'b0;
    if (!tick_i.module_present) begin
      st = ST_DETECT;
    end
    if (tick_i.a0_error) begin
      st = ST_INIT_RESET;
    end else if (tick_i.a2_error) begin
      st = ST_A0_DONE;
    end else begin
      case (st)
        ST_DETECT: begin
          if (tick_i.module_present) st = ST_INIT_RESET;
        end
        ST_INIT_RESET: begin
          init           = 1'b1;
          st             = ST_INIT_DONE;
          ctx_o.tol_left = tol_limit_i;
        end
        ST_INIT_DONE: begin
          if (tick_i.a0_ready_to_start) begin
            wr   = 1'b1;
            wval = ValA0Start;
            if (tick_i.start_acknowledged) begin
              st             = ST_A0_BUSY;
              ctx_o.tol_left = tol_limit_i;
            end else begin
              ctx_o.tol_left = ctx_i.tol_left - 8'd1;
              if (run_out) st = ST_INIT_RESET;
            end
          end
        end
        ST_A0_BUSY: begin
          if (tick_i.a0_complete) begin
            wr   = 1'b1;
            wval = (tick_i.multi_page_flag ? ValPageBit : 8'h00) |
                   (tick_i.addr_mode_flag  ? ValModeBit : 8'h00);
            st   = ST_A0_DONE;
          end
        end
        ST_A0_DONE: begin
          wr             = 1'b1;
          wval           = ValPollEn;
          st             = ST_A2_BUSY;
          ctx_o.tol_left = tol_limit_i;
        end
        ST_A2_BUSY: begin
          if (tick_i.a2_complete) begin
            st = ST_A2_DONE;
          end else begin
            ctx_o.tol_left = ctx_i.tol_left - 8'd1;
            if (run_out) st = ST_INIT_RESET;
          end
        end
        default: begin
        end
      endcase
    end
    ctx_o.state          = st;
    res_o.conf_write_valid = wr;
    res_o.conf_write_value = wval;
    res_o.init_pulse       = init;
    res_o.state_code       = st;
    res_o.connected        = tick_i.module_present && (st == ST_INIT_DONE);
  end

endmodule

// ===== design/pluggable_module_bringup_fsm.sv =====
// ----------------------------------------------------------------------------
// pluggable_module_bringup_fsm
// Bring-up sequencer for a pluggable optical module, one poll tick a request.
//
// Channel     Dir  Payload                         Handshake
// in_req_i    in   in_t  (status bits, A0 flags)   valid/ready
// out_res_o   out  out_t (write, init, state)      valid/ready
// cfg         in   tolerance_limit, 8 bits         cfg_we_i, no wait
//
// One request a cycle sustained while results are taken; a request is registered
// in the input register, then its result in the result register after the step logic.
// The state and tolerance counter advance in the cycle a request moves from
// the input register into the result register.
// Reset: state detect, tolerance count zero, tolerance limit 10.
// A stalled result holds the input register; the input side stalls only
// when both registers are full.
// ----------------------------------------------------------------------------
module pluggable_module_bringup_fsm
  import pmbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  pmbf_in_if.sink    in_req_i,
  pmbf_out_if.source out_res_o
);

  logic       in_vld_q;
  in_t        in_q;
  logic       out_vld_q;
  out_t       out_q;
  out_t       res_d;
  ctx_t       ctx_q;
  ctx_t       ctx_d;
  logic [7:0] tol_limit_q;
  logic       adv;
  logic       fire;

  assign adv   = !out_vld_q || out_res_o.ready;
  assign fire  = in_vld_q && adv;
  assign in_req_i.ready = !in_vld_q || adv;

  assign out_res_o.valid = out_vld_q;
  assign out_res_o.data  = out_q;

  pmbf_step u_step (
    .ctx_i       (ctx_q),
    .tol_limit_i (tol_limit_q),
    .tick_i      (in_q),
    .ctx_o       (ctx_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_limit_q <= TolLimitReset;
    end else if (cfg_we_i) begin
      tol_limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ctx_q     <= '{state: ST_DETECT, tol_left: 8'd0};
    end else begin
      if (in_req_i.ready) in_vld_q <= in_req_i.valid;
      if (adv) out_vld_q <= in_vld_q;
      if (fire) ctx_q <= ctx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req_i.valid && in_req_i.ready) in_q <= in_req_i.data;
    if (fire) out_q <= res_d;
  end

  a_init_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_d.init_pulse |=> out_q.state_code == ST_INIT_DONE &&
      !out_q.conf_write_valid)
    else $error("init pulse without move to init done");

  a_connected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.connected |-> out_q.state_code == ST_INIT_DONE)
    else $error("connected outside init done");

  a_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.conf_write_valid |-> out_q.conf_write_value == 8'h00)
    else $error("write value without write");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_q) && $stable(ctx_q))
    else $error("stalled request lost");

  a_state_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_q.state_code == ctx_q.state)
    else $error("result state differs from held state");

endmodule

// ===== bench/tb_pluggable_module_bringup_fsm.sv =====
// ----------------------------------------------------------------------------
// tb_pluggable_module_bringup_fsm
// Drives poll ticks into the bring-up controller with random idling on both
// channels. An in-bench model of the bring-up state and tolerance counter
// predicts every result, and each result is checked field by field. Several
// tolerance limits are used, the extremes and zero among them.
// ----------------------------------------------------------------------------
module tb_pluggable_module_bringup_fsm
  import pmbf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  pmbf_in_if  in_ch ();
  pmbf_out_if out_ch ();

  pluggable_module_bringup_fsm DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_ch),
    .out_res_o   (out_ch)
  );

  always #5 clk_i = ~clk_i;

  in_t        tick_q[$];
  out_t       result_q[$];
  out_t       want;
  state_e     model_st;
  logic [7:0] model_tol_left;
  logic [7:0] model_tol_limit;
  int         idle_pct;
  int         mismatches;
  int         quiet_cycles;

  function automatic out_t predict_tick(in_t t);
    out_t   r;
    state_e st;
    r  = '0;
    st = model_st;
    if (!t.module_present) st = ST_DETECT;
    if (t.a0_error) begin
      st = ST_INIT_RESET;
    end else if (t.a2_error) begin
      st = ST_A0_DONE;
    end else begin
      case (st)
        ST_DETECT: begin
          if (t.module_present) st = ST_INIT_RESET;
        end
        ST_INIT_RESET: begin
          r.init_pulse   = 1'b1;
          st             = ST_INIT_DONE;
          model_tol_left = model_tol_limit;
        end
        ST_INIT_DONE: begin
          if (t.a0_ready_to_start) begin
            r.conf_write_valid = 1'b1;
            r.conf_write_value = ValA0Start;
            if (t.start_acknowledged) begin
              st             = ST_A0_BUSY;
              model_tol_left = model_tol_limit;
            end else begin
              model_tol_left = model_tol_left - 8'd1;
              if (model_tol_left == 8'd0) st = ST_INIT_RESET;
            end
          end
        end
        ST_A0_BUSY: begin
          if (t.a0_complete) begin
            r.conf_write_valid = 1'b1;
            r.conf_write_value = (t.multi_page_flag ? ValPageBit : 8'h00) |
                                 (t.addr_mode_flag ? ValModeBit : 8'h00);
            st = ST_A0_DONE;
          end
        end
        ST_A0_DONE: begin
          r.conf_write_valid = 1'b1;
          r.conf_write_value = ValPollEn;
          st                 = ST_A2_BUSY;
          model_tol_left     = model_tol_limit;
        end
        ST_A2_BUSY: begin
          if (t.a2_complete) begin
            st = ST_A2_DONE;
          end else begin
            model_tol_left = model_tol_left - 8'd1;
            if (model_tol_left == 8'd0) st = ST_INIT_RESET;
          end
        end
        default: begin
        end
      endcase
    end
    model_st     = st;
    r.state_code = st;
    r.connected  = t.module_present && (st == ST_INIT_DONE);
    return r;
  endfunction

  // Mostly well-formed progress with rare errors and unplugs, some pure noise.
  function automatic in_t rand_tick();
    in_t t;
    t = in_t'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      t.module_present     = $urandom_range(0, 99) < 96;
      t.a0_ready_to_start  = $urandom_range(0, 99) < 70;
      t.a0_complete        = $urandom_range(0, 99) < 50;
      t.a2_complete        = $urandom_range(0, 99) < 50;
      t.a0_error           = $urandom_range(0, 99) < 3;
      t.a2_error           = $urandom_range(0, 99) < 3;
      t.start_acknowledged = $urandom_range(0, 99) < 55;
    end
    return t;
  endfunction

  // Present, ready, never acknowledged and no A2 completion: runs the counter out.
  function automatic in_t miss_tick();
    in_t t;
    t = in_t'($urandom);
    t.module_present     = 1'b1;
    t.a0_ready_to_start  = 1'b1;
    t.a0_error           = 1'b0;
    t.a2_error           = 1'b0;
    t.start_acknowledged = 1'b0;
    t.a2_complete        = 1'b0;
    return t;
  endfunction

  task automatic queue_random(int n);
    repeat (n) tick_q.push_back(rand_tick());
  endtask

  task automatic queue_run_down(int n);
    in_t t;
    t = rand_tick();
    t.module_present = 1'b0;
    t.a0_error       = 1'b0;
    t.a2_error       = 1'b0;
    tick_q.push_back(t);
    repeat (n) tick_q.push_back(miss_tick());
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || in_ch.valid || result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [7:0] lim);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_tol_limit = lim;
  endtask

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) result_q.push_back(predict_tick(in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= tick_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: no result expected, got %h", $time, out_ch.data);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("conf_write_valid", 8'(want.conf_write_valid),
                      8'(out_ch.data.conf_write_valid));
          check_field("conf_write_value", want.conf_write_value,
                      out_ch.data.conf_write_value);
          check_field("init_pulse", 8'(want.init_pulse), 8'(out_ch.data.init_pulse));
          check_field("state_code", 8'(want.state_code), 8'(out_ch.data.state_code));
          check_field("connected", 8'(want.connected), 8'(out_ch.data.connected));
        end
      end
      out_ch.ready <= $urandom_range(0, 99) >= idle_pct;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 8'h00;
    in_ch.valid     = 1'b0;
    in_ch.data      = '0;
    out_ch.ready    = 1'b0;
    model_st        = ST_DETECT;
    model_tol_left  = 8'h00;
    model_tol_limit = TolLimitReset;
    idle_pct        = 15;
    mismatches      = 0;
    quiet_cycles    = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // present, ready, a0 done, a2 done, a0 err, a2 err, ack, multi-page, addr mode
    tick_q.push_back(in_t'(9'b000000000));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b110000000));
    tick_q.push_back(in_t'(9'b110000100));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b101000000));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b100100000));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b100001000));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b100011000));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b110000100));
    tick_q.push_back(in_t'(9'b101000011));
    tick_q.push_back(in_t'(9'b100000000));
    tick_q.push_back(in_t'(9'b000010000));
    tick_q.push_back(in_t'(9'b000000000));
    tick_q.push_back(in_t'(9'b111111111));
    tick_q.push_back(in_t'(9'b011111111));
    tick_q.push_back(in_t'(9'b101000010));
    queue_random(150);
    wait_idle();

    write_limit(8'd1);
    queue_random(200);
    wait_idle();

    idle_pct = 0;
    write_limit(8'd255);
    queue_run_down(300);
    wait_idle();

    idle_pct = 15;
    write_limit(8'd0);
    queue_run_down(300);
    queue_random(50);
    wait_idle();

    write_limit(8'd2);
    queue_random(200);
    wait_idle();

    write_limit(TolLimitReset);
    queue_random(150);
    wait_idle();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== pluggable_module_bringup_fsm.f =====
design/pmbf_pkg.sv
design/pmbf_if.sv
design/pmbf_step.sv
design/pluggable_module_bringup_fsm.sv
bench/tb_pluggable_module_bringup_fsm.sv
